>>> hw/rtl/cri_pkg.sv
`timescale 1ns / 1ps

package cri_pkg;

  localparam int unsigned ProgLen = 36;

  // program positions with special handling
  localparam logic [5:0] POS_IDLE    = 6'd0;
  localparam logic [5:0] POS_SP_AF   = 6'd1;
  localparam logic [5:0] POS_HL_R    = 6'd4;
  localparam logic [5:0] POS_I       = 6'd7;
  localparam logic [5:0] POS_DE      = 6'd10;
  localparam logic [5:0] POS_BC      = 6'd11;
  localparam logic [5:0] POS_HL_ALT  = 6'd13;
  localparam logic [5:0] POS_DE_ALT  = 6'd14;
  localparam logic [5:0] POS_BC_ALT  = 6'd15;
  localparam logic [5:0] POS_AF_ALT  = 6'd18;
  localparam logic [5:0] POS_IX      = 6'd23;
  localparam logic [5:0] POS_IY      = 6'd27;
  localparam logic [5:0] POS_R_PATCH = 6'd28;
  localparam logic [5:0] POS_F_PATCH = 6'd32;
  localparam logic [5:0] POS_A_PATCH = 6'd33;
  localparam logic [5:0] POS_BUSREQ  = 6'd34;
  localparam logic [5:0] POS_END     = 6'(ProgLen);

  // captured register codes
  localparam logic [3:0] REG_PC     = 4'd0;
  localparam logic [3:0] REG_SP     = 4'd1;
  localparam logic [3:0] REG_AF     = 4'd2;
  localparam logic [3:0] REG_HL     = 4'd3;
  localparam logic [3:0] REG_R      = 4'd4;
  localparam logic [3:0] REG_I      = 4'd5;
  localparam logic [3:0] REG_DE     = 4'd6;
  localparam logic [3:0] REG_BC     = 4'd7;
  localparam logic [3:0] REG_HL_ALT = 4'd8;
  localparam logic [3:0] REG_DE_ALT = 4'd9;
  localparam logic [3:0] REG_BC_ALT = 4'd10;
  localparam logic [3:0] REG_AF_ALT = 4'd11;
  localparam logic [3:0] REG_IX     = 4'd12;
  localparam logic [3:0] REG_IY     = 4'd13;
  localparam logic [3:0] REG_LAST   = REG_IY;

  // index into the merged-register file
  localparam logic [1:0] MRG_AF_ALT = 2'd0;
  localparam logic [1:0] MRG_IX     = 2'd1;
  localparam logic [1:0] MRG_IY     = 2'd2;
  localparam int unsigned MrgRegs   = 3;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam int unsigned PayloadW = 33;
  localparam int unsigned TdataW   = 40;

  typedef struct packed {
    logic        opcode_fetch;
    logic        action;
    logic [7:0]  bus_data;
    logic [15:0] address;
  } in_item_t;

  typedef struct packed {
    logic        last;
    logic        sequence_done;
    logic        bus_request;
    logic [15:0] capture_value;
    logic [3:0]  capture_reg;
    logic        capture_valid;
    logic [7:0]  inject_byte;
    logic        inject_valid;
    logic        held;
  } result_t;

  function automatic logic [7:0] prog_byte(input logic [5:0] pos, input logic [6:0] r_byte,
                                           input logic [7:0] f_byte, input logic [7:0] a_byte);
    logic [7:0] b;
    case (pos)
      6'd0:  b = 8'hF5;
      6'd1:  b = 8'hED;
      6'd2:  b = 8'h5F;
      6'd3:  b = 8'h77;
      6'd4:  b = 8'hED;
      6'd5:  b = 8'h57;
      6'd6:  b = 8'h77;
      6'd7:  b = 8'h33;
      6'd8:  b = 8'h33;
      6'd9:  b = 8'h12;
      6'd10: b = 8'h02;
      6'd11: b = 8'hD9;
      6'd12: b = 8'h77;
      6'd13: b = 8'h12;
      6'd14: b = 8'h02;
      6'd15: b = 8'hD9;
      6'd16: b = 8'h08;
      6'd17: b = 8'hF5;
      6'd18: b = 8'h33;
      6'd19: b = 8'h33;
      6'd20: b = 8'h08;
      6'd21: b = 8'hDD;
      6'd22: b = 8'hE5;
      6'd23: b = 8'h33;
      6'd24: b = 8'h33;
      6'd25: b = 8'hFD;
      6'd26: b = 8'hE5;
      6'd27: b = 8'h3E;
      6'd28: b = {1'b0, r_byte};
      6'd29: b = 8'hED;
      6'd30: b = 8'h4F;
      6'd31: b = 8'hF1;
      6'd32: b = f_byte;
      6'd33: b = a_byte;
      6'd34: b = 8'h18;
      6'd35: b = 8'hDE;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> hw/rtl/cri_core.sv
`timescale 1ns / 1ps

module cri_core import cri_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data,
  input  logic     accept,
  input  in_item_t item,
  output result_t  res0,
  output result_t  res1,
  output logic     two_results
);

  logic        dbg_r;
  logic [5:0]  pos_r, pos_nxt;
  logic        wh_r, wh_nxt;
  logic [6:0]  rb_r, rb_nxt;
  logic [7:0]  fb_r, fb_nxt;
  logic [7:0]  ab_r, ab_nxt;
  logic [15:0] mrg_r [MrgRegs];
  logic [15:0] mrg_val;
  logic        mrg_we;
  logic [1:0]  mrg_idx;
  logic [15:0] mrg_old;
  logic [5:0]  pos_inc;
  logic [6:0]  r_val;

  assign mrg_old = mrg_r[mrg_idx];
  assign pos_inc = pos_r + 6'd1;
  assign r_val   = item.bus_data[6:0] - 7'd3;

  always_comb begin
    res0        = '0;
    res1        = '0;
    two_results = 1'b0;
    pos_nxt     = pos_r;
    wh_nxt      = wh_r;
    rb_nxt      = rb_r;
    fb_nxt      = fb_r;
    ab_nxt      = ab_r;
    mrg_we      = 1'b0;
    mrg_idx     = MRG_AF_ALT;
    mrg_val     = '0;

    case (pos_r)
      POS_AF_ALT: mrg_idx = MRG_AF_ALT;
      POS_IX:     mrg_idx = MRG_IX;
      POS_IY:     mrg_idx = MRG_IY;
      default:    mrg_idx = MRG_AF_ALT;
    endcase

    if (!dbg_r || (pos_r == POS_IDLE && (item.action == ACT_WRITE || !item.opcode_fetch))) begin
      res0.last = 1'b1;
    end else if (item.action == ACT_READ) begin
      res0.held         = 1'b1;
      res0.inject_valid = 1'b1;
      res0.inject_byte  = prog_byte(pos_r, rb_r, fb_r, ab_r);
      if (pos_r == POS_IDLE) begin
        res0.capture_valid = 1'b1;
        res0.capture_reg   = REG_PC;
        res0.capture_value = item.address;
      end
      wh_nxt           = 1'b0;
      pos_nxt          = pos_inc;
      res0.bus_request = (pos_inc == POS_BUSREQ);
      if (pos_inc >= POS_END) begin
        res0.sequence_done = 1'b1;
        pos_nxt            = POS_IDLE;
      end
      res0.last = 1'b1;
    end else begin
      res0.held = 1'b1;
      res1.held = 1'b1;
      unique case (pos_r)
        POS_SP_AF: begin
          if (!wh_r) begin
            res0.capture_valid = 1'b1;
            res0.capture_reg   = REG_SP;
            res0.capture_value = item.address + 16'd1;
            res1.capture_valid = 1'b1;
            res1.capture_reg   = REG_AF;
            res1.capture_value = {item.bus_data, 8'h00};
            ab_nxt             = item.bus_data;
            wh_nxt             = 1'b1;
            two_results        = 1'b1;
          end else begin
            res0.capture_valid = 1'b1;
            res0.capture_reg   = REG_AF;
            res0.capture_value = {ab_r, item.bus_data};
            fb_nxt             = item.bus_data;
          end
        end
        POS_HL_R: begin
          res0.capture_valid = 1'b1;
          res0.capture_reg   = REG_HL;
          res0.capture_value = item.address;
          res1.capture_valid = 1'b1;
          res1.capture_reg   = REG_R;
          res1.capture_value = {9'd0, r_val};
          rb_nxt             = r_val - 7'd2;
          two_results        = 1'b1;
        end
        POS_I: begin
          res0.capture_valid = 1'b1;
          res0.capture_reg   = REG_I;
          res0.capture_value = {8'h00, item.bus_data};
        end
        POS_DE, POS_BC, POS_HL_ALT, POS_DE_ALT, POS_BC_ALT: begin
          res0.capture_valid = 1'b1;
          res0.capture_value = item.address;
          case (pos_r)
            POS_DE:     res0.capture_reg = REG_DE;
            POS_BC:     res0.capture_reg = REG_BC;
            POS_HL_ALT: res0.capture_reg = REG_HL_ALT;
            POS_DE_ALT: res0.capture_reg = REG_DE_ALT;
            default:    res0.capture_reg = REG_BC_ALT;
          endcase
        end
        POS_AF_ALT, POS_IX, POS_IY: begin
          if (!wh_r) begin
            mrg_val = {item.bus_data, mrg_old[7:0]};
            wh_nxt  = 1'b1;
          end else begin
            mrg_val = {mrg_old[15:8], item.bus_data};
          end
          mrg_we             = 1'b1;
          res0.capture_valid = 1'b1;
          res0.capture_value = mrg_val;
          case (pos_r)
            POS_AF_ALT: res0.capture_reg = REG_AF_ALT;
            POS_IX:     res0.capture_reg = REG_IX;
            default:    res0.capture_reg = REG_IY;
          endcase
        end
        default: ;
      endcase
      if (two_results) begin
        res1.last = 1'b1;
      end else begin
        res0.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbg_r <= 1'b0;
      pos_r <= POS_IDLE;
      wh_r  <= 1'b0;
      rb_r  <= '0;
      fb_r  <= '0;
      ab_r  <= '0;
      for (int i = 0; i < MrgRegs; i++) begin
        mrg_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        dbg_r <= cfg_wr_data;
      end
      if (accept) begin
        pos_r <= pos_nxt;
        wh_r  <= wh_nxt;
        rb_r  <= rb_nxt;
        fb_r  <= fb_nxt;
        ab_r  <= ab_nxt;
        if (mrg_we) begin
          mrg_r[mrg_idx] <= mrg_val;
        end
      end
    end
  end

endmodule

>>> hw/rtl/cpu_register_capture_injector_top.sv
`timescale 1ns / 1ps
// channel | ports                              | transaction
// in      | in_tvalid/in_tready/in_tdata/tuser | one stalled bus cycle
// out     | out_tvalid/out_tready/out_tdata    | one result, tlast on final one
// cfg     | cfg_wr_en/cfg_wr_data              | debug_enable write
//
// one bus cycle per clock while in_tready is high, its first result on the output the cycle after acceptance
// a write that captures two registers fills both queue entries and holds
// in_tready low while both results are queued
// rst_n clears debug enable, position, write half, restore bytes, merged registers and queue count
// in_tready is low while two results are queued, or one is queued and out_tready is low

module cpu_register_capture_injector_top import cri_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // address[15:0], bus_data[23:16]
  input  logic [1:0]        in_tuser,   // action[0], opcode_fetch[1]
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [TdataW-1:0] out_tdata,  // held, inject_valid, inject_byte, capture_valid,
                                        // capture_reg, capture_value, bus_request,
                                        // sequence_done, zero pad
  output logic              out_tlast
);

  in_item_t   item;
  result_t    res0, res1;
  logic       two_results;
  logic       accept, pop;
  logic [1:0] cnt_r, cnt_nxt;
  result_t    slot0_r, slot0_nxt;
  result_t    slot1_r, slot1_nxt;

  assign item.address      = in_tdata[15:0];
  assign item.bus_data     = in_tdata[23:16];
  assign item.action       = in_tuser[0];
  assign item.opcode_fetch = in_tuser[1];

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign in_tready  = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign accept     = in_tvalid && in_tready;

  assign out_tdata = {{(TdataW - PayloadW){1'b0}}, slot0_r[PayloadW-1:0]};
  assign out_tlast = slot0_r.last;

  cri_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .item        (item),
    .res0        (res0),
    .res1        (res1),
    .two_results (two_results)
  );

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (accept) begin
      slot0_nxt = res0;
      slot1_nxt = res1;
      cnt_nxt   = two_results ? 2'd2 : 2'd1;
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

>>> hw/rtl/cri_checker.sv
`timescale 1ns / 1ps

module cri_checker import cri_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [TdataW-1:0] out_tdata,
  input logic              out_tlast
);

  result_t res;

  assign res = {out_tlast, out_tdata[PayloadW-1:0]};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result dropped or changed while stalled");

  a_inject_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.inject_valid || res.capture_valid) |-> res.held)
    else $error("injection or capture on a cycle not held");

  a_capture_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.capture_valid |-> res.capture_reg <= REG_LAST)
    else $error("capture register code out of range");

  a_busreq_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res.bus_request || res.sequence_done) |-> res.inject_valid && out_tlast)
    else $error("bus request or sequence end outside a program read");

endmodule

bind cpu_register_capture_injector_top cri_checker u_cri_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> dv/cpu_register_capture_injector_top_tb.sv
`timescale 1ns / 1ps

module cpu_register_capture_injector_top_tb import cri_pkg::*;;

  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 1300;

  localparam logic [0:35][7:0] PROGRAM_ROM = {
    8'hF5, 8'hED, 8'h5F, 8'h77, 8'hED, 8'h57, 8'h77, 8'h33, 8'h33, 8'h12, 8'h02, 8'hD9,
    8'h77, 8'h12, 8'h02, 8'hD9, 8'h08, 8'hF5, 8'h33, 8'h33, 8'h08, 8'hDD, 8'hE5, 8'h33,
    8'h33, 8'hFD, 8'hE5, 8'h3E, 8'h00, 8'hED, 8'h4F, 8'hF1, 8'h00, 8'h00, 8'h18, 8'hDE
  };

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic              cfg_wr_data;
  logic              in_tvalid;
  logic              in_tready;
  logic [23:0]       in_tdata;
  logic [1:0]        in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [TdataW-1:0] out_tdata;
  logic              out_tlast;

  cpu_register_capture_injector_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  // injector state as the checker sees it
  logic        dbg_en;
  logic [5:0]  prog_pos;
  logic        wr_half;
  logic [6:0]  r_restore;
  logic [7:0]  f_restore;
  logic [7:0]  a_restore;
  logic [15:0] cpu_regs [0:13];

  result_t pending_results [$];
  int      mismatches;
  int      cycle_count;
  int      enabled_items;
  bit      idle_on;
  bit      debug_setting;
  int      sink_hold;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] rand_addr();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] program_byte(logic [5:0] pos);
    if (pos == POS_R_PATCH) return {1'b0, r_restore};
    if (pos == POS_F_PATCH) return f_restore;
    if (pos == POS_A_PATCH) return a_restore;
    if (pos < POS_END) return PROGRAM_ROM[pos];
    return 8'h00;
  endfunction

  function automatic result_t capture_result(logic [3:0] code, logic [15:0] value);
    result_t r;
    r = '0;
    r.held = 1'b1;
    r.capture_valid = 1'b1;
    r.capture_reg = code;
    r.capture_value = value;
    return r;
  endfunction

  function automatic void merge_byte(logic [3:0] code, logic [7:0] data);
    if (!wr_half) begin
      cpu_regs[code][15:8] = data;
      wr_half = 1'b1;
    end else begin
      cpu_regs[code][7:0] = data;
    end
  endfunction

  function automatic void predict_bus_cycle(logic act, logic fetch, logic [15:0] addr,
                                            logic [7:0] data);
    result_t   r0;
    result_t   r1;
    logic [5:0] pos;
    logic [6:0] r_val;
    bit         two;
    r0 = '0;
    r1 = '0;
    two = 1'b0;
    pos = prog_pos;
    if (!dbg_en || (pos == POS_IDLE && (act == ACT_WRITE || !fetch))) begin
      r0.last = 1'b1;
      pending_results.push_back(r0);
      return;
    end
    r0.held = 1'b1;
    if (act == ACT_READ) begin
      if (pos == POS_IDLE) begin
        cpu_regs[REG_PC] = addr;
        r0 = capture_result(REG_PC, addr);
      end
      r0.inject_valid = 1'b1;
      r0.inject_byte = program_byte(pos);
      wr_half = 1'b0;
      pos = pos + 6'd1;
      if (pos == POS_BUSREQ) r0.bus_request = 1'b1;
      if (pos == POS_END) begin
        r0.sequence_done = 1'b1;
        pos = POS_IDLE;
      end
      prog_pos = pos;
      r0.last = 1'b1;
      pending_results.push_back(r0);
      return;
    end
    case (pos)
      POS_SP_AF: begin
        if (!wr_half) begin
          cpu_regs[REG_SP] = addr + 16'd1;
          cpu_regs[REG_AF] = {data, 8'h00};
          a_restore = data;
          wr_half = 1'b1;
          r0 = capture_result(REG_SP, cpu_regs[REG_SP]);
          r1 = capture_result(REG_AF, cpu_regs[REG_AF]);
          two = 1'b1;
        end else begin
          cpu_regs[REG_AF][7:0] = data;
          f_restore = data;
          r0 = capture_result(REG_AF, cpu_regs[REG_AF]);
        end
      end
      POS_HL_R: begin
        r_val = data[6:0] - 7'd3;
        cpu_regs[REG_HL] = addr;
        cpu_regs[REG_R] = {9'd0, r_val};
        r_restore = r_val - 7'd2;
        r0 = capture_result(REG_HL, addr);
        r1 = capture_result(REG_R, cpu_regs[REG_R]);
        two = 1'b1;
      end
      POS_I: begin
        cpu_regs[REG_I] = {8'h00, data};
        r0 = capture_result(REG_I, cpu_regs[REG_I]);
      end
      POS_DE:     begin cpu_regs[REG_DE] = addr;     r0 = capture_result(REG_DE, addr); end
      POS_BC:     begin cpu_regs[REG_BC] = addr;     r0 = capture_result(REG_BC, addr); end
      POS_HL_ALT: begin cpu_regs[REG_HL_ALT] = addr; r0 = capture_result(REG_HL_ALT, addr); end
      POS_DE_ALT: begin cpu_regs[REG_DE_ALT] = addr; r0 = capture_result(REG_DE_ALT, addr); end
      POS_BC_ALT: begin cpu_regs[REG_BC_ALT] = addr; r0 = capture_result(REG_BC_ALT, addr); end
      POS_AF_ALT: begin
        merge_byte(REG_AF_ALT, data);
        r0 = capture_result(REG_AF_ALT, cpu_regs[REG_AF_ALT]);
      end
      POS_IX: begin
        merge_byte(REG_IX, data);
        r0 = capture_result(REG_IX, cpu_regs[REG_IX]);
      end
      POS_IY: begin
        merge_byte(REG_IY, data);
        r0 = capture_result(REG_IY, cpu_regs[REG_IY]);
      end
      default: ;
    endcase
    if (two) begin
      r1.last = 1'b1;
      pending_results.push_back(r0);
      pending_results.push_back(r1);
    end else begin
      r0.last = 1'b1;
      pending_results.push_back(r0);
    end
  endfunction

  function automatic void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  function automatic void check_result();
    result_t e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected transaction, actual data %h last %b", $time, out_tdata, out_tlast);
      mismatches++;
      return;
    end
    e = pending_results.pop_front();
    compare_field("held", 16'(e.held), 16'(out_tdata[0]));
    compare_field("inject_valid", 16'(e.inject_valid), 16'(out_tdata[1]));
    compare_field("inject_byte", 16'(e.inject_byte), 16'(out_tdata[9:2]));
    compare_field("capture_valid", 16'(e.capture_valid), 16'(out_tdata[10]));
    compare_field("capture_reg", 16'(e.capture_reg), 16'(out_tdata[14:11]));
    compare_field("capture_value", e.capture_value, out_tdata[30:15]);
    compare_field("bus_request", 16'(e.bus_request), 16'(out_tdata[31]));
    compare_field("sequence_done", 16'(e.sequence_done), 16'(out_tdata[32]));
    compare_field("last", 16'(e.last), 16'(out_tlast));
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else if (rst_n) begin
      if (cfg_wr_en) dbg_en = cfg_wr_data;
      if (in_tvalid && in_tready)
        predict_bus_cycle(in_tuser[0], in_tuser[1], in_tdata[15:0], in_tdata[23:16]);
      if (out_tvalid && out_tready) check_result();
    end
  end

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_tready <= 1'b0;
    end else begin
      sink_hold = pick_gap();
      out_tready <= (sink_hold == 0);
      if (sink_hold > 0) sink_hold--;
    end
  end

  task automatic drive_bus_cycle(logic act, logic fetch, logic [15:0] addr, logic [7:0] data);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= {fetch, act};
    in_tdata <= {data, addr};
    do @(posedge clk); while (!in_tready);
    if (debug_setting) enabled_items++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_debug(bit en);
    drain_results();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= en;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    debug_setting = en;
  endtask

  function automatic int usual_writes(logic [5:0] pos);
    case (pos)
      POS_SP_AF, POS_AF_ALT, POS_IX, POS_IY: return 2;
      POS_HL_R, POS_I, POS_DE, POS_BC, POS_HL_ALT, POS_DE_ALT, POS_BC_ALT: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic run_random_program();
    logic [5:0] pos;
    int         n_wr;
    drive_bus_cycle(ACT_READ, 1'b1, rand_addr(), rand_byte());
    pos = 6'd1;
    while (pos != POS_IDLE) begin
      n_wr = usual_writes(pos);
      if ($urandom_range(0, 9) == 0) n_wr = $urandom_range(0, 3);
      repeat (n_wr) drive_bus_cycle(ACT_WRITE, 1'($urandom), rand_addr(), rand_byte());
      if ($urandom_range(0, 149) == 0) return;
      drive_bus_cycle(ACT_READ, $urandom_range(0, 9) == 0, rand_addr(), rand_byte());
      pos = (pos == POS_END - 6'd1) ? POS_IDLE : pos + 6'd1;
    end
  endtask

  task automatic test_debug_disabled();
    drive_bus_cycle(ACT_READ, 1'b1, 16'hFFFF, 8'hFF);
    drive_bus_cycle(ACT_WRITE, 1'b1, 16'h0000, 8'h00);
    drive_bus_cycle(ACT_READ, 1'b0, 16'h5AA5, 8'h81);
  endtask

  task automatic test_idle_cycles();
    set_debug(1'b1);
    drive_bus_cycle(ACT_WRITE, 1'b1, 16'hFFFF, 8'hFF);
    drive_bus_cycle(ACT_WRITE, 1'b0, 16'h0000, 8'h00);
    drive_bus_cycle(ACT_READ, 1'b0, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_sequence_start();
    drive_bus_cycle(ACT_READ, 1'b1, 16'hFFFF, 8'h00);
    drive_bus_cycle(ACT_WRITE, 1'b0, 16'hFFFF, 8'hFF);
    drive_bus_cycle(ACT_WRITE, 1'b0, 16'h0000, 8'h00);
    drive_bus_cycle(ACT_WRITE, 1'b1, 16'h1234, 8'hA5);
    drive_bus_cycle(ACT_READ, 1'b1, 16'h0000, 8'h00);
    drive_bus_cycle(ACT_READ, 1'b0, 16'h8001, 8'h7F);
    drive_bus_cycle(ACT_READ, 1'b0, 16'h8002, 8'h80);
    drive_bus_cycle(ACT_WRITE, 1'b0, 16'hFFFF, 8'h00);
    drive_bus_cycle(ACT_WRITE, 1'b0, 16'h0000, 8'hFF);
    drive_bus_cycle(ACT_READ, 1'b0, 16'h8004, 8'h00);
  endtask

  task automatic test_resume_after_pause();
    set_debug(1'b0);
    drive_bus_cycle(ACT_READ, 1'b1, 16'hC000, 8'h3C);
    drive_bus_cycle(ACT_WRITE, 1'b0, 16'hC001, 8'hC3);
    set_debug(1'b1);
    drive_bus_cycle(ACT_READ, 1'b0, 16'hC002, 8'h00);
    drive_bus_cycle(ACT_WRITE, 1'b0, 16'hFFFF, 8'h80);
  endtask

  task automatic test_random_programs();
    int stop_at;
    stop_at = enabled_items + RANDOM_ITEMS;
    while (enabled_items < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      set_debug($urandom_range(0, 4) != 0);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 5))
            drive_bus_cycle(1'($urandom), 1'($urandom), rand_addr(), rand_byte());
        run_random_program();
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    sink_hold = 0;
    idle_on = 1'b1;
    debug_setting = 1'b0;
    mismatches = 0;
    cycle_count = 0;
    enabled_items = 0;
    dbg_en = 1'b0;
    prog_pos = POS_IDLE;
    wr_half = 1'b0;
    r_restore = '0;
    f_restore = '0;
    a_restore = '0;
    for (int i = 0; i < 14; i++) cpu_regs[i] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_debug_disabled();
    test_idle_cycles();
    test_sequence_start();
    test_resume_after_pause();
    test_random_programs();

    drain_results();
    repeat (20) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected transactions never arrived", $time, pending_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
